// File: rtl/core/fhcc_pkg.sv
// Shared types and constants of the frame header and checksum checker.
// Depends on nothing; the accumulator, the judge and the top level import it.
`default_nettype none

package fhcc_pkg;

  localparam int unsigned HASH_MUL  = 31;
  localparam int unsigned MIN_FRAME = 8;
  localparam int unsigned TAIL_LEN  = 4;
  localparam int unsigned COUNT_MAX = 15;
  localparam int unsigned CNT_W     = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_MAJOR    = 3'd4,
    ST_MINOR    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAGIC = 2'd0,
    CFG_MAJOR = 2'd1,
    CFG_MINOR = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [15:0]        expected_magic;
    logic signed [7:0]  required_major;
    logic signed [7:0]  minimum_minor;
  } cfg_regs_t;

  // Snapshot of one finished frame, handed from the accumulator to the judge.
  typedef struct packed {
    logic               valid;
    logic               too_short;
    logic [15:0]        magic;
    logic signed [7:0]  major;
    logic signed [7:0]  minor;
    logic [31:0]        hash;
    logic [31:0]        tail;
  } chk_req_t;

endpackage

`default_nettype wire

// File: rtl/core/fhcc_if.sv
// Channel interfaces of the frame header and checksum checker: byte requests,
// result requests and configuration writes. No dependencies.
`default_nettype none

interface fhcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       final_byte;
  modport source (output valid, frame_byte, final_byte, input ready);
  modport sink   (input valid, frame_byte, final_byte, output ready);
endinterface

interface fhcc_result_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [7:0] seen_major;
  logic signed [7:0] seen_minor;
  modport source (output valid, status, seen_major, seen_minor, input ready);
  modport sink   (input valid, status, seen_major, seen_minor, output ready);
endinterface

interface fhcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fhcc_accum.sv
// Per-byte accumulator: header capture, delay line, running hash and byte count.
// Depends on fhcc_pkg and fhcc_byte_if.
`default_nettype none

module fhcc_accum (
  input  wire logic          clk,
  input  wire logic          rst,
  fhcc_byte_if.sink          frm,
  input  wire logic          take,
  output fhcc_pkg::chk_req_t chk
);
  import fhcc_pkg::*;

  logic [31:0]      hash;
  logic [31:0]      tail;
  logic [15:0]      magic;
  logic [7:0]       major;
  logic [7:0]       minor;
  logic [CNT_W-1:0] cnt;

  logic [31:0]      hash_next;
  logic [31:0]      tail_next;
  logic [15:0]      magic_next;
  logic [7:0]       major_next;
  logic [7:0]       minor_next;
  logic [CNT_W-1:0] cnt_next;
  logic             accept;

  assign frm.ready = !chk.valid || take;
  assign accept    = frm.valid && frm.ready;

  always_comb begin
    hash_next  = hash;
    magic_next = magic;
    major_next = major;
    minor_next = minor;
    // The byte leaving the delay line enters the hash.
    if (cnt >= CNT_W'(TAIL_LEN)) begin
      hash_next = (hash << 5) - hash + {24'd0, tail[7:0]};
    end
    tail_next = {frm.frame_byte, tail[31:8]};
    case (cnt)
      CNT_W'(0): magic_next = {magic[15:8], frm.frame_byte};
      CNT_W'(1): magic_next = {frm.frame_byte, magic[7:0]};
      CNT_W'(2): major_next = frm.frame_byte;
      CNT_W'(3): minor_next = frm.frame_byte;
      default:   magic_next = magic;
    endcase
    cnt_next = (cnt < CNT_W'(COUNT_MAX)) ? cnt + CNT_W'(1) : cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      tail      <= '0;
      magic     <= '0;
      major     <= '0;
      minor     <= '0;
      cnt       <= '0;
      chk.valid <= 1'b0;
    end else begin
      chk.valid <= (chk.valid && !take) || (accept && frm.final_byte);
      if (accept) begin
        if (frm.final_byte) begin
          chk.too_short <= cnt_next < CNT_W'(MIN_FRAME);
          chk.magic     <= magic_next;
          chk.major     <= major_next;
          chk.minor     <= minor_next;
          chk.hash      <= hash_next;
          chk.tail      <= tail_next;
          hash          <= '0;
          tail          <= '0;
          magic         <= '0;
          major         <= '0;
          minor         <= '0;
          cnt           <= '0;
        end else begin
          hash  <= hash_next;
          tail  <= tail_next;
          magic <= magic_next;
          major <= major_next;
          minor <= minor_next;
          cnt   <= cnt_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fhcc_judge.sv
// Status decision for a finished frame and the result output register.
// Depends on fhcc_pkg and fhcc_result_if.
`default_nettype none

module fhcc_judge (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fhcc_pkg::chk_req_t  chk,
  input  wire fhcc_pkg::cfg_regs_t cfg_regs,
  output logic                     take,
  fhcc_result_if.source            res
);
  import fhcc_pkg::*;

  status_t           status_d;
  status_t           status_q;
  logic signed [7:0] major_q;
  logic signed [7:0] minor_q;
  logic              res_valid;

  assign take = !res_valid || res.ready;

  always_comb begin
    if (chk.too_short) begin
      status_d = ST_SHORT;
    end else if (chk.magic != cfg_regs.expected_magic) begin
      status_d = ST_MAGIC;
    end else if (chk.tail != chk.hash) begin
      status_d = ST_CHECKSUM;
    end else if (chk.major != cfg_regs.required_major) begin
      status_d = ST_MAJOR;
    end else if (chk.minor < cfg_regs.minimum_minor) begin
      status_d = ST_MINOR;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= chk.valid;
    end
    if (take && chk.valid) begin
      status_q <= status_d;
      // A frame that is too short reports no version bytes.
      major_q  <= chk.too_short ? 8'sd0 : chk.major;
      minor_q  <= chk.too_short ? 8'sd0 : chk.minor;
    end
  end

  assign res.valid      = res_valid;
  assign res.status     = status_q;
  assign res.seen_major = major_q;
  assign res.seen_minor = minor_q;

endmodule

`default_nettype wire

// File: rtl/core/frame_header_checksum_checker_unit.sv
// Top level of the frame header and checksum checker: configuration registers,
// accumulator and judge. Depends on fhcc_pkg, the fhcc interfaces, fhcc_accum, fhcc_judge.
//
//   Port  Role    Request carries
//   frm   sink    frame_byte, final_byte
//   res   source  status, seen_major, seen_minor
//   cfg   sink    index, data (always ready)
//
// One byte is accepted per cycle while frm.ready is high; the running hash is updated
// at the accepting edge. After its final byte, a result passes through the frame
// snapshot register and then the register that holds the decided status.
// Reset is synchronous and clears the frame state, the configuration and both valids.
// A stalled result stops every further byte only once the snapshot register is full.
`default_nettype none

module frame_header_checksum_checker_unit (
  input  wire logic     clk,
  input  wire logic     rst,
  fhcc_byte_if.sink     frm,
  fhcc_result_if.source res,
  fhcc_cfg_if.sink      cfg
);
  import fhcc_pkg::*;

  cfg_regs_t cfg_regs;
  chk_req_t  chk;
  logic      take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_MAGIC: cfg_regs.expected_magic <= cfg.data;
        CFG_MAJOR: cfg_regs.required_major <= cfg.data[7:0];
        CFG_MINOR: cfg_regs.minimum_minor  <= cfg.data[7:0];
        default:   cfg_regs <= cfg_regs;
      endcase
    end
  end

  fhcc_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .frm  (frm),
    .take (take),
    .chk  (chk)
  );

  fhcc_judge u_judge (
    .clk      (clk),
    .rst      (rst),
    .chk      (chk),
    .cfg_regs (cfg_regs),
    .take     (take),
    .res      (res)
  );

  a_final_makes_snapshot: assert property (@(posedge clk) disable iff (rst)
    frm.valid && frm.ready && frm.final_byte |=> chk.valid)
    else $error("final byte accepted without a frame snapshot");

  a_snapshot_only_on_final: assert property (@(posedge clk) disable iff (rst)
    !(frm.valid && frm.ready && frm.final_byte) |=> !$rose(chk.valid))
    else $error("frame snapshot appeared without a final byte");

  a_snapshot_held: assert property (@(posedge clk) disable iff (rst)
    chk.valid && !take |=> chk.valid && $stable(chk))
    else $error("frame snapshot lost while the result register was full");

  a_short_no_versions: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == ST_SHORT |-> res.seen_major == 8'sd0 && res.seen_minor == 8'sd0)
    else $error("short frame reported version bytes");

endmodule

`default_nettype wire
